### src/indexed_insert_remove_array_top_macros.svh
// assertion macros for the insert/remove array
`ifndef INDEXED_INSERT_REMOVE_ARRAY_TOP_MACROS_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define IIRA_CHECK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("iira check failed");
`define IIRA_CHECK_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("iira check failed");
`else
`define IIRA_CHECK(lbl, clk, rstn, prop)
`define IIRA_CHECK_NR(lbl, clk, prop)
`endif
`endif

### src/iira_pkg.sv
// shared types and constants for the insert/remove array
`default_nettype none
package iira_pkg;
  localparam int DEF_CAPACITY = 16;
  localparam int CMD_W        = 3;
  localparam int IDX_W        = 5;
  localparam int LEN_W        = 5;
  localparam int DATA_W       = 32;

  localparam logic [LEN_W-1:0] START_LEN_RST = LEN_W'(5);

  localparam logic [CMD_W-1:0] CMD_FILL   = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_WRITE  = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_REMOVE = CMD_W'(4);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILL,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         idx;
    logic [LEN_W-1:0]         fill_n;
    logic signed [DATA_W-1:0] val;
  } cell_ctrl_t;
endpackage
`default_nettype wire

### src/indexed_insert_remove_array_top.sv
// Ordered array of signed 32-bit entries held in a row of cells, one cell per entry.
// Fill, read, write, insert and remove are all handled alike: a command is accepted in
// every cycle that the result register is free or being emptied, and its result beat
// appears in the next cycle. This is possible because the cell row shifts every
// entry at once, and a single read select serves the entries an index can reach.
// Entry contents are undefined after reset and are never cleared; only the length
// resets (to zero), so no clearing pass is needed. start_length resets to 5.
`default_nettype none
module indexed_insert_remove_array_top import iira_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_wr_en,
  input  wire logic [LEN_W-1:0]         cfg_wr_data,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic [IDX_W-1:0]         in_index,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic [1:0]                    out_status,
  output logic [LEN_W-1:0]              out_length
);
  logic [LEN_W-1:0]         start_len_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] rd_r;
  status_t                  status_r;
  logic [LEN_W-1:0]         len_r;
  logic                     acc;
  cell_ctrl_t               ctrl;
  status_t                  status;
  logic signed [DATA_W-1:0] rd_val;
  logic [LEN_W-1:0]         length;
  logic signed [DATA_W-1:0] entries [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  iira_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cmd       (in_command),
    .idx       (in_index),
    .val       (in_value),
    .start_len (start_len_r),
    .entries   (entries),
    .ctrl      (ctrl),
    .status    (status),
    .rd_val    (rd_val),
    .length    (length)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = entries[g];
    end else begin : g_left
      assign left_w = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = entries[g];
    end else begin : g_right
      assign right_w = entries[g+1];
    end
    iira_cell #(.INDEX(g)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (entries[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_len_r <= START_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) start_len_r <= cfg_wr_data;
      if (acc) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r     <= rd_val;
      status_r <= status;
      len_r    <= length;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = rd_r;
  assign out_status     = status_r;
  assign out_length     = len_r;
endmodule
`default_nettype wire

### src/iira_cell.sv
// one entry of the array, shifting with its neighbors
`default_nettype none
module iira_cell import iira_pkg::*; #(
  parameter int INDEX = 0
) (
  input  wire                       clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic signed [DATA_W-1:0] left_i,
  input  wire logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0]  data_o
);
  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_FILL: begin
        if (INDEX < int'(ctrl.fill_n)) data_nxt = ctrl.val;
      end
      OP_WRITE: begin
        if (INDEX == int'(ctrl.idx)) data_nxt = ctrl.val;
      end
      OP_INSERT: begin
        if (INDEX == int'(ctrl.idx)) data_nxt = ctrl.val;
        else if (INDEX > int'(ctrl.idx)) data_nxt = left_i;
      end
      OP_REMOVE: begin
        if (INDEX >= int'(ctrl.idx)) data_nxt = right_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
endmodule
`default_nettype wire

### src/iira_ctrl.sv
// command decode, range checks, read select and live length
`default_nettype none
`include "indexed_insert_remove_array_top_macros.svh"
module iira_ctrl import iira_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           acc,
  input  wire logic [CMD_W-1:0]         cmd,
  input  wire logic [IDX_W-1:0]         idx,
  input  wire logic signed [DATA_W-1:0] val,
  input  wire logic [LEN_W-1:0]         start_len,
  input  wire logic signed [DATA_W-1:0] entries [CAPACITY],
  output cell_ctrl_t                    ctrl,
  output status_t                       status,
  output logic signed [DATA_W-1:0]      rd_val,
  output logic [LEN_W-1:0]              length
);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int RD_N = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);
  localparam logic [CMPW-1:0] CAP_EXT = CMPW'(CAPACITY);

  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [CMPW-1:0]          idx_ext;
  logic [CMPW-1:0]          cnt_ext;
  logic [CMPW-1:0]          start_ext;
  logic [CMPW-1:0]          len_ext;
  logic                     in_rng;
  logic signed [DATA_W-1:0] sel;
  op_t                      op;

  always_comb begin
    idx_ext   = CMPW'(idx);
    cnt_ext   = CMPW'(count_r);
    start_ext = CMPW'(start_len);
    in_rng    = idx_ext < cnt_ext;
    sel       = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (idx_ext == CMPW'(i)) sel = entries[i];
    end
    op        = OP_NONE;
    status    = ST_OK;
    rd_val    = '0;
    count_nxt = count_r;
    unique case (cmd)
      CMD_FILL: begin
        op        = OP_FILL;
        count_nxt = (start_ext > CAP_EXT) ? CW'(CAPACITY) : CW'(start_ext);
      end
      CMD_READ: begin
        if (in_rng) rd_val = sel;
        else status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (in_rng) op = OP_WRITE;
        else status = ST_RANGE;
      end
      CMD_INSERT: begin
        if (idx_ext > cnt_ext) begin
          status = ST_RANGE;
        end else if (cnt_ext == CAP_EXT) begin
          status = ST_FULL;
        end else begin
          op        = OP_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (in_rng) begin
          op        = OP_REMOVE;
          count_nxt = count_r - CW'(1);
        end else begin
          status = ST_RANGE;
        end
      end
      default: op = OP_NONE;
    endcase
    len_ext     = CMPW'(count_nxt);
    length      = len_ext[LEN_W-1:0];
    ctrl.op     = acc ? op : OP_NONE;
    ctrl.idx    = idx;
    ctrl.fill_n = start_len;
    ctrl.val    = val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

  `IIRA_CHECK(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `IIRA_CHECK(a_insert_grows, clk, rst_n,
    acc && cmd == CMD_INSERT && status == ST_OK |=> count_r == $past(count_r) + CW'(1))
  `IIRA_CHECK(a_hold_on_error, clk, rst_n, !(acc && status == ST_OK) |=> $stable(count_r))
  `IIRA_CHECK(a_full_at_cap, clk, rst_n, status == ST_FULL |-> count_r == CW'(CAPACITY))
endmodule
`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the indexed insert/remove array
`default_nettype none
module tb_top import iira_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP         = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 500000;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = CMD_W'(7);

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
  } array_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
    logic [LEN_W-1:0]         length;
  } array_reply_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0]         cfg_wr_data = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command  = '0;
  logic [IDX_W-1:0]         in_index    = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic [1:0]               out_status;
  logic [LEN_W-1:0]         out_length;

  array_cmd_t   cmd_backlog[$];
  array_reply_t predicted_replies[$];

  // shadow of the array as the block should hold it
  logic signed [DATA_W-1:0] shadow_entries[CAP];
  int shadow_len = 0;
  int fill_len   = int'(START_LEN_RST);

  // length as it will stand once everything queued so far has run
  int plan_len  = 0;
  int plan_fill = int'(START_LEN_RST);

  int         errors     = 0;
  int         cycles     = 0;
  int         idle_left  = 0;
  int         stall_left = 0;
  bit         steady     = 1'b0;
  logic       took;
  array_cmd_t beat;
  array_reply_t want;

  indexed_insert_remove_array_top #(.CAPACITY(CAP)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

  always #4 clk = ~clk;

  function automatic array_reply_t apply_array_cmd(logic [CMD_W-1:0] cmd,
                                                   logic [IDX_W-1:0] idx,
                                                   logic signed [DATA_W-1:0] val);
    array_reply_t r;
    int n;
    r.read_value = '0;
    r.status     = ST_OK;
    case (cmd)
      CMD_FILL: begin
        n = (fill_len > CAP) ? CAP : fill_len;
        for (int i = 0; i < n; i++) shadow_entries[i] = val;
        shadow_len = n;
      end
      CMD_READ: begin
        if (idx < shadow_len) r.read_value = shadow_entries[idx];
        else r.status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (idx < shadow_len) shadow_entries[idx] = val;
        else r.status = ST_RANGE;
      end
      CMD_INSERT: begin
        if (idx > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx] = val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (idx < shadow_len) begin
          for (int i = int'(idx); i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(shadow_len);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                    logic signed [DATA_W-1:0] val);
    cmd_backlog.push_back('{cmd, idx, val});
    case (cmd)
      CMD_FILL: plan_len = (plan_fill > CAP) ? CAP : plan_fill;
      CMD_INSERT: begin
        if (idx <= plan_len && plan_len < CAP) plan_len++;
      end
      CMD_REMOVE: begin
        if (idx < plan_len) plan_len--;
      end
      default: ;
    endcase
  endfunction

  // mostly in-range accesses, with grow_pct steering inserts against removes
  function automatic void plan_random(int count, int grow_pct);
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 4) cmd = CMD_FILL;
      else if (r < 7) cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else if (r < 29) cmd = CMD_READ;
      else if (r < 46) cmd = CMD_WRITE;
      else if (r < 46 + (grow_pct * 54) / 100) cmd = CMD_INSERT;
      else cmd = CMD_REMOVE;
      if ($urandom_range(0, 9) < 2) idx = IDX_W'($urandom_range(0, 31));
      else if (cmd == CMD_INSERT) idx = IDX_W'($urandom_range(0, plan_len));
      else if (plan_len == 0) idx = '0;
      else idx = IDX_W'($urandom_range(0, plan_len - 1));
      queue_cmd(cmd, idx, pick_value());
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || predicted_replies.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_start_length(logic [LEN_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fill_len  = int'(v);
    plan_fill = int'(v);
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) predicted_replies.push_back(apply_array_cmd(in_command, in_index, in_value));
      if (!in_valid || took) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          beat = cmd_backlog.pop_front();
          in_valid   <= 1'b1;
          in_command <= beat.cmd;
          in_index   <= beat.idx;
          in_value   <= beat.val;
          idle_left = pick_gap();
          if ($urandom_range(0, 59) == 0) steady = !steady;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          $error("result beat with nothing predicted");
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_length);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [LEN_W-1:0] start_len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty array, then build and probe with the reset start length
    queue_cmd(CMD_READ, '0, '0);
    queue_cmd(CMD_REMOVE, '0, '0);
    queue_cmd(CMD_INSERT, IDX_W'(1), 32'sd7);
    queue_cmd(CMD_INSERT, '0, 32'sh7fff_ffff);
    queue_cmd(CMD_INSERT, '0, 32'sh8000_0000);
    queue_cmd(CMD_INSERT, IDX_W'(2), -32'sd1);
    queue_cmd(CMD_READ, '0, '0);
    queue_cmd(CMD_READ, IDX_W'(1), '0);
    queue_cmd(CMD_READ, IDX_W'(2), '0);
    queue_cmd(CMD_READ, IDX_W'(3), '0);
    queue_cmd(CMD_WRITE, IDX_W'(1), '0);
    queue_cmd(CMD_WRITE, IDX_W'(31), 32'sd3);
    queue_cmd(CMD_SPARE_LO, IDX_W'(31), -32'sd1);
    queue_cmd(CMD_SPARE_HI, '0, 32'sd9);
    queue_cmd(CMD_REMOVE, IDX_W'(2), '0);
    queue_cmd(CMD_REMOVE, '0, '0);
    queue_cmd(CMD_FILL, '0, 32'sh5a5a_5a5a);
    queue_cmd(CMD_READ, IDX_W'(4), '0);

    // full array
    set_start_length(LEN_W'(CAP));
    queue_cmd(CMD_FILL, '0, 32'sh0000_ffff);
    queue_cmd(CMD_INSERT, IDX_W'(16), 32'sd1);
    queue_cmd(CMD_INSERT, IDX_W'(17), 32'sd1);
    queue_cmd(CMD_INSERT, '0, 32'sd1);
    queue_cmd(CMD_READ, IDX_W'(15), '0);
    queue_cmd(CMD_REMOVE, IDX_W'(15), '0);
    queue_cmd(CMD_INSERT, IDX_W'(15), 32'sd1);

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: start_len = LEN_W'(31);
        1: start_len = '0;
        2: start_len = LEN_W'(1);
        3: start_len = LEN_W'(15);
        4: start_len = LEN_W'(CAP);
        5: start_len = LEN_W'(2);
        default: start_len = LEN_W'($urandom_range(0, 31));
      endcase
      set_start_length(start_len);
      queue_cmd(CMD_FILL, '0, pick_value());
      for (int c = 0; c < 4; c++) plan_random(24, (c % 2 == 0) ? 80 : 20);
    end

    wait_idle();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+src
src/iira_pkg.sv
src/iira_cell.sv
src/iira_ctrl.sv
src/indexed_insert_remove_array_top.sv
tb/tb_top.sv
